// ===== src/mf3_pkg.sv =====
package mf3_pkg;

    // Default frame limits; storage and counter widths follow from these
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_W    = 8;
    localparam int WIN_TAPS = 9;

    // Configuration registers
    localparam int IMG_W_CFG_W = 11;
    localparam int IMG_H_CFG_W = 13;
    localparam logic [IMG_W_CFG_W-1:0] IMG_W_RST = 11'd640;
    localparam logic [IMG_H_CFG_W-1:0] IMG_H_RST = 13'd480;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_IMG_W = 1'b0;
    localparam logic [0:0] REG_IMG_H = 1'b1;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // What a pixel causes: a median for the position up-left, a zero for its own
    typedef struct packed {
        logic has_med;
        logic border;
    } t_kind;

endpackage

// ===== src/mf3_front.sv =====
module mf3_front #(
    parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF,
    localparam int COL_W    = $clog2(MAX_WIDTH),
    localparam int ROW_W    = $clog2(MAX_HEIGHT),
    localparam int TAP_BITS = mf3_pkg::WIN_TAPS * mf3_pkg::PIX_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [mf3_pkg::PIX_W-1:0] i_pixel,
    input  logic                      i_frame_start,
    input  logic [COL_W:0]            i_width,
    input  logic [ROW_W:0]            i_height,
    output logic                      o_q_valid,
    input  logic                      i_q_ready,
    output logic [TAP_BITS-1:0]       o_q_taps,
    output logic [ROW_W-1:0]          o_q_row,
    output logic [COL_W-1:0]          o_q_col,
    output mf3_pkg::t_kind            o_q_kind
);

    logic                      acc;
    logic                      b_adv;
    logic                      b_needs;
    logic [COL_W-1:0]          col0;
    logic [COL_W-1:0]          c_a;
    logic [ROW_W-1:0]          row0;
    logic [ROW_W:0]            row1;
    logic [ROW_W-1:0]          r_a;
    logic                      wrap_c;
    logic [COL_W:0]            col_inc;
    logic [ROW_W:0]            row_inc;
    logic [COL_W-1:0]          n_col;
    logic [ROW_W-1:0]          n_row;
    mf3_pkg::t_kind            kind_a;
    logic [mf3_pkg::PIX_W-1:0] b_top;
    logic [mf3_pkg::PIX_W-1:0] b_mid;

    logic [COL_W-1:0]          r_col;
    logic [ROW_W-1:0]          r_row;
    logic                      r_b_valid;
    logic [mf3_pkg::PIX_W-1:0] r_b_pix;
    logic [ROW_W-1:0]          r_b_row;
    logic [COL_W-1:0]          r_b_col;
    mf3_pkg::t_kind            r_b_kind;
    logic [mf3_pkg::PIX_W-1:0] r_rd_top;
    logic [mf3_pkg::PIX_W-1:0] r_rd_mid;
    logic                      r_fwd;
    logic [mf3_pkg::PIX_W-1:0] r_fwd_top;
    logic [mf3_pkg::PIX_W-1:0] r_fwd_mid;
    logic [mf3_pkg::PIX_W-1:0] r_win [0:5];
    logic [mf3_pkg::PIX_W-1:0] r_two_up [0:MAX_WIDTH-1];
    logic [mf3_pkg::PIX_W-1:0] r_one_up [0:MAX_WIDTH-1];

    // Position of the incoming pixel, with frame start and wrap applied
    always_comb begin
        col0    = i_frame_start ? '0 : r_col;
        row0    = i_frame_start ? '0 : r_row;
        wrap_c  = {1'b0, col0} >= i_width;
        c_a     = wrap_c ? '0 : col0;
        row1    = {1'b0, row0} + (ROW_W+1)'(wrap_c);
        r_a     = (row1 >= i_height) ? '0 : row1[ROW_W-1:0];
        col_inc = {1'b0, c_a} + (COL_W+1)'(1);
        row_inc = {1'b0, r_a} + (ROW_W+1)'(1);

        kind_a.border  = (r_a == '0) || (c_a == '0) || (row_inc >= i_height)
                         || (col_inc >= i_width);
        kind_a.has_med = (r_a >= ROW_W'(2)) && (c_a >= COL_W'(2));

        if (col_inc >= i_width) begin
            n_col = '0;
            n_row = (row_inc >= i_height) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = r_a;
        end
    end

    assign b_needs    = r_b_kind.has_med | r_b_kind.border;
    assign b_adv      = r_b_valid && (!b_needs || i_q_ready);
    assign o_in_ready = !r_b_valid || b_adv;
    assign acc        = i_in_valid && o_in_ready;

    assign b_top = r_fwd ? r_fwd_top : r_rd_top;
    assign b_mid = r_fwd ? r_fwd_mid : r_rd_mid;

    assign o_q_valid = r_b_valid && b_needs;
    assign o_q_taps  = {r_b_pix, b_mid, b_top, r_win[5], r_win[4], r_win[3],
                        r_win[2], r_win[1], r_win[0]};
    assign o_q_row   = r_b_row;
    assign o_q_col   = r_b_col;
    assign o_q_kind  = r_b_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (acc) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= b_top;
                r_win[4] <= b_mid;
                r_win[5] <= r_b_pix;
            end
        end
    end

    // Stage B payload; bypass the line write still in flight at the same column
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_pix   <= i_pixel;
            r_b_row   <= r_a;
            r_b_col   <= c_a;
            r_b_kind  <= kind_a;
            r_fwd     <= r_b_valid && (r_b_col == c_a);
            r_fwd_top <= b_mid;
            r_fwd_mid <= r_b_pix;
        end
    end

    // Line buffers: read on accept, write back when stage B retires
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_top <= r_two_up[c_a];
            r_rd_mid <= r_one_up[c_a];
        end
        if (b_adv) begin
            r_two_up[r_b_col] <= b_mid;
            r_one_up[r_b_col] <= r_b_pix;
        end
    end

endmodule

// ===== src/mf3_queue.sv =====
module mf3_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mf3_pkg::QUEUE_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic             push;
    logic             pop;
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== src/mf3_back.sv =====
module mf3_back #(
    parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF,
    localparam int COL_W    = $clog2(MAX_WIDTH),
    localparam int ROW_W    = $clog2(MAX_HEIGHT),
    localparam int PW       = mf3_pkg::PIX_W,
    localparam int TAP_BITS = mf3_pkg::WIN_TAPS * mf3_pkg::PIX_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_pop,
    input  logic [TAP_BITS-1:0] i_q_taps,
    input  logic [ROW_W-1:0]    i_q_row,
    input  logic [COL_W-1:0]    i_q_col,
    input  mf3_pkg::t_kind      i_q_kind,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [ROW_W-1:0]    o_row,
    output logic [COL_W-1:0]    o_col,
    output logic [PW-1:0]       o_value,
    output logic                o_last
);

    function automatic logic [3*PW-1:0] sort3(input logic [PW-1:0] a,
                                              input logic [PW-1:0] b,
                                              input logic [PW-1:0] c);
        logic [PW-1:0] x;
        logic [PW-1:0] y;
        logic [PW-1:0] z;
        logic [PW-1:0] t;
        x = a;
        y = b;
        z = c;
        if (x > y) begin t = x; x = y; y = t; end
        if (y > z) begin t = y; y = z; z = t; end
        if (x > y) begin t = x; x = y; y = t; end
        return {z, y, x};
    endfunction

    function automatic logic [PW-1:0] max3(input logic [PW-1:0] a,
                                           input logic [PW-1:0] b,
                                           input logic [PW-1:0] c);
        logic [PW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [PW-1:0] min3(input logic [PW-1:0] a,
                                           input logic [PW-1:0] b,
                                           input logic [PW-1:0] c);
        logic [PW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [PW-1:0] med3(input logic [PW-1:0] a,
                                           input logic [PW-1:0] b,
                                           input logic [PW-1:0] c);
        logic [PW-1:0] lo;
        logic [PW-1:0] hi;
        logic [PW-1:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    logic                 out_free;
    logic                 two_res;
    logic                 emit;
    logic                 send_med;
    logic                 s3_done;
    logic                 s3_free;
    logic                 s2_free;
    logic                 s1_free;
    logic [3*PW-1:0]      srt [0:2];

    logic                 r_s1_valid;
    logic [PW-1:0]        r_s1_lo [0:2];
    logic [PW-1:0]        r_s1_md [0:2];
    logic [PW-1:0]        r_s1_hi [0:2];
    logic [ROW_W-1:0]     r_s1_row;
    logic [COL_W-1:0]     r_s1_col;
    mf3_pkg::t_kind       r_s1_kind;

    logic                 r_s2_valid;
    logic [PW-1:0]        r_s2_a;
    logic [PW-1:0]        r_s2_b;
    logic [PW-1:0]        r_s2_c;
    logic [ROW_W-1:0]     r_s2_row;
    logic [COL_W-1:0]     r_s2_col;
    mf3_pkg::t_kind       r_s2_kind;

    logic                 r_s3_valid;
    logic [PW-1:0]        r_s3_med;
    logic [ROW_W-1:0]     r_s3_row;
    logic [COL_W-1:0]     r_s3_col;
    mf3_pkg::t_kind       r_s3_kind;
    logic                 r_ph;

    logic                 r_o_valid;
    logic [ROW_W-1:0]     r_o_row;
    logic [COL_W-1:0]     r_o_col;
    logic [PW-1:0]        r_o_val;
    logic                 r_o_last;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            srt[k] = sort3(i_q_taps[(3*k)*PW +: PW], i_q_taps[(3*k+1)*PW +: PW],
                           i_q_taps[(3*k+2)*PW +: PW]);
        end
    end

    // An item with a median and a border zero holds stage 3 for two transactions
    assign out_free = !r_o_valid || i_ready;
    assign two_res  = r_s3_kind.has_med && r_s3_kind.border;
    assign emit     = r_s3_valid && out_free;
    assign send_med = r_s3_kind.has_med && !r_ph;
    assign s3_done  = emit && (!two_res || r_ph);
    assign s3_free  = !r_s3_valid || s3_done;
    assign s2_free  = !r_s2_valid || s3_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign o_q_pop  = i_q_valid && s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_ph       <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= o_q_pop;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_free) begin
                r_s3_valid <= r_s2_valid;
            end
            if (emit) begin
                r_ph <= two_res && !r_ph;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            for (int k = 0; k < 3; k++) begin
                r_s1_lo[k] <= srt[k][0 +: PW];
                r_s1_md[k] <= srt[k][PW +: PW];
                r_s1_hi[k] <= srt[k][2*PW +: PW];
            end
            r_s1_row  <= i_q_row;
            r_s1_col  <= i_q_col;
            r_s1_kind <= i_q_kind;
        end
        if (s2_free) begin
            r_s2_a    <= max3(r_s1_lo[0], r_s1_lo[1], r_s1_lo[2]);
            r_s2_b    <= med3(r_s1_md[0], r_s1_md[1], r_s1_md[2]);
            r_s2_c    <= min3(r_s1_hi[0], r_s1_hi[1], r_s1_hi[2]);
            r_s2_row  <= r_s1_row;
            r_s2_col  <= r_s1_col;
            r_s2_kind <= r_s1_kind;
        end
        if (s3_free) begin
            r_s3_med  <= med3(r_s2_a, r_s2_b, r_s2_c);
            r_s3_row  <= r_s2_row;
            r_s3_col  <= r_s2_col;
            r_s3_kind <= r_s2_kind;
        end
        if (emit) begin
            if (send_med) begin
                r_o_row  <= r_s3_row - ROW_W'(1);
                r_o_col  <= r_s3_col - COL_W'(1);
                r_o_val  <= r_s3_med;
                r_o_last <= !r_s3_kind.border;
            end else begin
                r_o_row  <= r_s3_row;
                r_o_col  <= r_s3_col;
                r_o_val  <= '0;
                r_o_last <= 1'b1;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_row   = r_o_row;
    assign o_col   = r_o_col;
    assign o_value = r_o_val;
    assign o_last  = r_o_last;

endmodule

// ===== src/median_filter_3x3_top.sv =====
// Path: stage B, queue, three median stages, output register.
// Throughput: one pixel per cycle while the output side does not stall; a pixel that
//   causes a median and a border zero holds stage 3 until both results are sent, so intake
//   can slow along the last row from column two on and the last column from row two on.
// Reset: synchronous, active low; clears position, window, pipeline and the registers
//   (640 x 480); line buffers are not cleared and hold nothing valid until written.
module median_filter_3x3_top #(
    parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF,
    localparam int COL_W    = $clog2(MAX_WIDTH),
    localparam int ROW_W    = $clog2(MAX_HEIGHT),
    localparam int OUT_BITS = ROW_W + COL_W + mf3_pkg::PIX_W,
    localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Pixel stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [mf3_pkg::PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel
    input  logic                           s_axis_tuser,   // [0] frame_start
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [OUT_TW-1:0]              m_axis_tdata,   // out_row, out_col, out_value, zero pad
    output logic                           m_axis_tlast,   // last_of_run
    // Register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mf3_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mf3_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mf3_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int TAP_BITS = mf3_pkg::WIN_TAPS * mf3_pkg::PIX_W;
    localparam int KIND_W   = $bits(mf3_pkg::t_kind);
    localparam int Q_W      = KIND_W + TAP_BITS + ROW_W + COL_W;
    localparam int WC_W     = (mf3_pkg::IMG_W_CFG_W > COL_W + 1) ? mf3_pkg::IMG_W_CFG_W
                                                                  : COL_W + 1;
    localparam int HC_W     = (mf3_pkg::IMG_H_CFG_W > ROW_W + 1) ? mf3_pkg::IMG_H_CFG_W
                                                                  : ROW_W + 1;

    logic [mf3_pkg::IMG_W_CFG_W-1:0] r_img_w;
    logic [mf3_pkg::IMG_H_CFG_W-1:0] r_img_h;
    logic                            cfg_wr;
    logic [WC_W-1:0]                 w_raw;
    logic [HC_W-1:0]                 h_raw;
    logic [COL_W:0]                  width;
    logic [ROW_W:0]                  height;

    logic                            fq_valid;
    logic                            fq_ready;
    logic [TAP_BITS-1:0]             fq_taps;
    logic [ROW_W-1:0]                fq_row;
    logic [COL_W-1:0]                fq_col;
    mf3_pkg::t_kind                  fq_kind;
    logic [Q_W-1:0]                  q_head;
    logic                            q_valid;
    logic                            q_pop;
    logic [ROW_W-1:0]                o_row;
    logic [COL_W-1:0]                o_col;
    logic [mf3_pkg::PIX_W-1:0]       o_value;

    // Register port: zero wait states, write on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= mf3_pkg::IMG_W_RST;
            r_img_h <= mf3_pkg::IMG_H_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                mf3_pkg::REG_IMG_W: r_img_w <= pwdata[mf3_pkg::IMG_W_CFG_W-1:0];
                mf3_pkg::REG_IMG_H: r_img_h <= pwdata[mf3_pkg::IMG_H_CFG_W-1:0];
                default:            r_img_w <= r_img_w;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            mf3_pkg::REG_IMG_W: prdata = mf3_pkg::APB_DATA_W'(r_img_w);
            mf3_pkg::REG_IMG_H: prdata = mf3_pkg::APB_DATA_W'(r_img_h);
            default:            prdata = '0;
        endcase
    end

    // Saturate the frame size to [1, MAX]; a zero register counts as one
    always_comb begin
        w_raw = WC_W'(r_img_w);
        h_raw = HC_W'(r_img_h);
        if (w_raw == '0) begin
            width = (COL_W+1)'(1);
        end else if (w_raw > WC_W'(MAX_WIDTH)) begin
            width = (COL_W+1)'(MAX_WIDTH);
        end else begin
            width = w_raw[COL_W:0];
        end
        if (h_raw == '0) begin
            height = (ROW_W+1)'(1);
        end else if (h_raw > HC_W'(MAX_HEIGHT)) begin
            height = (ROW_W+1)'(MAX_HEIGHT);
        end else begin
            height = h_raw[ROW_W:0];
        end
    end

    // Front: position tracking, line buffers, window, result classification
    mf3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_pixel       (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_width       (width),
        .i_height      (height),
        .o_q_valid     (fq_valid),
        .i_q_ready     (fq_ready),
        .o_q_taps      (fq_taps),
        .o_q_row       (fq_row),
        .o_q_col       (fq_col),
        .o_q_kind      (fq_kind)
    );

    // Queue: decouple pixel intake from result delivery
    mf3_queue #(
        .WIDTH (Q_W),
        .DEPTH (mf3_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_data  ({fq_kind, fq_taps, fq_row, fq_col}),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_head)
    );

    // Back: median network and result sequencing
    mf3_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_taps  (q_head[ROW_W+COL_W +: TAP_BITS]),
        .i_q_row   (q_head[COL_W +: ROW_W]),
        .i_q_col   (q_head[COL_W-1:0]),
        .i_q_kind  (mf3_pkg::t_kind'(q_head[Q_W-1 -: KIND_W])),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_row     (o_row),
        .o_col     (o_col),
        .o_value   (o_value),
        .o_last    (m_axis_tlast)
    );

    // Pack the result transaction, row in the lowest bits
    assign m_axis_tdata = OUT_TW'({o_value, o_col, o_row});

endmodule

// ===== src/mf3_checker.sv =====
module mf3_props #(
    parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF,
    localparam int COL_W    = $clog2(MAX_WIDTH),
    localparam int ROW_W    = $clog2(MAX_HEIGHT),
    localparam int OUT_BITS = ROW_W + COL_W + mf3_pkg::PIX_W,
    localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [OUT_TW-1:0]              m_axis_tdata,
    input logic                           m_axis_tlast
);

    // Drop any result in flight on reset
    a_rst_out_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Take a pixel straight after reset
    a_rst_in_ready: assert property (@(posedge i_clk) !i_rst_n |=> s_axis_tready)
        else $error("pixel side not ready after reset");

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A median followed by a border zero goes out without a gap
    a_pair_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("second result of a pair not presented at once");

    // A non-final result is a median, never at row or column zero
    a_median_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast
        |-> (m_axis_tdata[ROW_W-1:0] != '0) && (m_axis_tdata[ROW_W +: COL_W] != '0))
        else $error("median result at an edge position");

endmodule

bind median_filter_3x3_top mf3_props #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
) u_mf3_props (.*);

// ===== test/mf3_checker.sv =====
`timescale 1ns / 1ps

module mf3_checker #(
    parameter int MAX_W  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_H  = mf3_pkg::MAX_HEIGHT_DEF,
    parameter int RES_TW = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_pix_valid,
    input  logic                           i_pix_ready,
    input  logic [mf3_pkg::PIX_W-1:0]      i_pix_data,
    input  logic                           i_pix_frame_start,
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic [RES_TW-1:0]              i_res_data,     // [11:0] out_row, [21:12] out_col,
                                                           // [29:22] out_value
    input  logic                           i_res_last,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [mf3_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [mf3_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        logic [11:0] out_row;
        logic [9:0]  out_col;
        logic [7:0]  out_value;
        logic        last_of_run;
    } t_filt_res;

    logic [7:0]                      row_two_up [MAX_W];
    logic [7:0]                      row_one_up [MAX_W];
    logic [7:0]                      win_px     [6];
    int unsigned                     cur_row;
    int unsigned                     cur_col;
    logic [mf3_pkg::IMG_W_CFG_W-1:0] cfg_width;
    logic [mf3_pkg::IMG_H_CFG_W-1:0] cfg_height;
    t_filt_res                       filt_q[$];
    int                              fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Median of nine: the tap with at most four below it and at least five at or below it
    function automatic logic [7:0] median_of_nine(input logic [71:0] taps);
        int         below;
        int         not_above;
        logic [7:0] cand;
        for (int i = 0; i < mf3_pkg::WIN_TAPS; i++) begin
            cand      = taps[i*8 +: 8];
            below     = 0;
            not_above = 0;
            for (int j = 0; j < mf3_pkg::WIN_TAPS; j++) begin
                if (taps[j*8 +: 8] < cand) below++;
                if (taps[j*8 +: 8] <= cand) not_above++;
            end
            if (below <= 4 && not_above >= 5) return cand;
        end
        return 8'h00;
    endfunction

    task automatic predict_pixel(input logic [7:0] pix, input logic frame_start);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        logic [7:0]  top_px;
        logic [7:0]  mid_px;
        logic        border;
        t_filt_res   res;
        w = clamp_dim(32'(cfg_width), MAX_W);
        h = clamp_dim(32'(cfg_height), MAX_H);
        if (frame_start) begin
            cur_row = 0;
            cur_col = 0;
        end
        // wrap a position left beyond a shrunken image
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= h) cur_row = 0;
        r      = cur_row;
        c      = cur_col;
        top_px = row_two_up[c];
        mid_px = row_one_up[c];
        border = (r == 0) || (c == 0) || (r + 1 >= h) || (c + 1 >= w);
        if (r >= 2 && c >= 2) begin
            res.out_row     = 12'(r - 1);
            res.out_col     = 10'(c - 1);
            res.out_value   = median_of_nine({pix, mid_px, top_px, win_px[5], win_px[4],
                                              win_px[3], win_px[2], win_px[1], win_px[0]});
            res.last_of_run = !border;
            filt_q.push_back(res);
        end
        if (border) begin
            res.out_row     = 12'(r);
            res.out_col     = 10'(c);
            res.out_value   = 8'h00;
            res.last_of_run = 1'b1;
            filt_q.push_back(res);
        end
        row_two_up[c] = mid_px;
        row_one_up[c] = pix;
        win_px[0] = win_px[3];
        win_px[1] = win_px[4];
        win_px[2] = win_px[5];
        win_px[3] = top_px;
        win_px[4] = mid_px;
        win_px[5] = pix;
        cur_col = c + 1;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row = r + 1;
            if (cur_row >= h) cur_row = 0;
        end
    endtask

    task automatic check_result();
        t_filt_res want;
        if (filt_q.size() == 0) begin
            $error("unexpected result: out_row %0d out_col %0d out_value %0d",
                   i_res_data[11:0], i_res_data[21:12], i_res_data[29:22]);
            fail_total++;
            return;
        end
        want = filt_q.pop_front();
        if (i_res_data[11:0] !== want.out_row) begin
            $error("out_row: expected %0d, actual %0d", want.out_row, i_res_data[11:0]);
            fail_total++;
        end
        if (i_res_data[21:12] !== want.out_col) begin
            $error("out_col: expected %0d, actual %0d", want.out_col, i_res_data[21:12]);
            fail_total++;
        end
        if (i_res_data[29:22] !== want.out_value) begin
            $error("out_value: expected %0d, actual %0d", want.out_value, i_res_data[29:22]);
            fail_total++;
        end
        if (i_res_last !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", want.last_of_run, i_res_last);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_W; k++) begin
                row_two_up[k] = 8'h00;
                row_one_up[k] = 8'h00;
            end
            for (int k = 0; k < 6; k++) win_px[k] = 8'h00;
            cur_row    = 0;
            cur_col    = 0;
            cfg_width  = mf3_pkg::IMG_W_RST;
            cfg_height = mf3_pkg::IMG_H_RST;
            filt_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[mf3_pkg::APB_ADDR_W-1:2] == mf3_pkg::REG_IMG_W) begin
                    cfg_width = i_pwdata[mf3_pkg::IMG_W_CFG_W-1:0];
                end
                if (i_paddr[mf3_pkg::APB_ADDR_W-1:2] == mf3_pkg::REG_IMG_H) begin
                    cfg_height = i_pwdata[mf3_pkg::IMG_H_CFG_W-1:0];
                end
            end
            if (i_pix_valid && i_pix_ready) predict_pixel(i_pix_data, i_pix_frame_start);
            if (i_res_valid && i_res_ready) check_result();
        end
        o_pending <= filt_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int RES_TW       = 32;
    localparam int RANDOM_ITEMS = 400;
    localparam int LARGE_ITEMS  = 700;
    localparam int QUIET_CYCLES = 16;        // pipeline depth plus queue, with margin
    localparam int LIMIT_CYCLES = 600000;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [mf3_pkg::PIX_W-1:0]        s_axis_tdata;   // [7:0] pixel
    logic                             s_axis_tuser;   // [0] frame_start
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [RES_TW-1:0]                m_axis_tdata;   // [11:0] out_row, [21:12] out_col,
                                                      // [29:22] out_value, [31:30] zero
    logic                             m_axis_tlast;   // last_of_run
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [mf3_pkg::APB_ADDR_W-1:0]   paddr;
    logic [mf3_pkg::APB_DATA_W-1:0]   pwdata;
    logic [mf3_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;

    int                               fail_count;
    int                               pending;
    int                               cycle_count = 0;
    int                               stall_left  = 0;
    logic                             quiet_run   = 1'b0;   // no idling on either side while set
    logic                             force_start = 1'b0;   // next pixel must open a frame
    int unsigned                      width_now   = 640;    // effective width, after saturation

    median_filter_3x3_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mf3_checker #(.RES_TW(RES_TW)) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pix_valid       (s_axis_tvalid),
        .i_pix_ready       (s_axis_tready),
        .i_pix_data        (s_axis_tdata),
        .i_pix_frame_start (s_axis_tuser),
        .i_res_valid       (m_axis_tvalid),
        .i_res_ready       (m_axis_tready),
        .i_res_data        (m_axis_tdata),
        .i_res_last        (m_axis_tlast),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always #6 i_clk = ~i_clk;

    // Idle length for either side: mostly none or a few cycles, now and then a long one
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Pixel values: mostly uniform, with many extremes and near-equal values so that
    // the median sees plenty of ties
    function automatic logic [7:0] pick_pixel();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) return 8'($urandom_range(0, 255));
        if (roll < 8) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 3));
    endfunction

    // Receiver: stall at random, hold ready high throughout a quiet run
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet_run) begin
            m_axis_tready <= !i_rst_n ? 1'b0 : 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            stall_left = gap_len();
            m_axis_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // Watchdog: end the run if the traffic never drains
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // One register write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [0:0] idx, input logic [mf3_pkg::APB_DATA_W-1:0] value);
        int unsigned eff;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == mf3_pkg::REG_IMG_W) begin
            eff = 32'(value[mf3_pkg::IMG_W_CFG_W-1:0]);
            if (eff < 1) eff = 1;
            if (eff > mf3_pkg::MAX_WIDTH_DEF) eff = mf3_pkg::MAX_WIDTH_DEF;
            // A wider row would reach line buffer columns this frame never filled:
            // open a fresh frame with the next pixel.
            if (eff > width_now) force_start = 1'b1;
            width_now = eff;
        end
    endtask

    // Offer one pixel, after a random gap, and hold it until the block takes the transaction.
    // Valid stays high into the next call when no gap follows.
    task automatic push_pixel(input logic [7:0] pix, input logic frame_start);
        int idle;
        idle = quiet_run ? 0 : gap_len();
        if (idle > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= frame_start || force_start;
        force_start = 1'b0;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Drop valid, let every expected result arrive, then give the pipeline time to empty
    // of pixels that produce nothing.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int                             random_sent;
        int                             n_items;
        int                             roll;
        logic [mf3_pkg::APB_DATA_W-1:0] raw_w;
        logic [mf3_pkg::APB_DATA_W-1:0] raw_h;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a 4x4 frame, first half extreme values, so the last column from row
        // two on yields a median and a border zero from the same pixel, and the last row
        // is all border.
        write_reg(mf3_pkg::REG_IMG_W, 32'd4);
        write_reg(mf3_pkg::REG_IMG_H, 32'd4);
        for (int k = 0; k < 16; k++) begin
            push_pixel((k < 8) ? (k[0] ? 8'hFF : 8'h00) : pick_pixel(), k == 0);
        end
        // Carry on without a frame start: position wraps to the top of a new frame
        for (int k = 0; k < 6; k++) push_pixel(pick_pixel(), 1'b0);
        // Shrink the image mid-frame: the column wraps to the next row, which lies past
        // the new height and wraps to row 0. Width 2 and height 0 make every pixel border.
        settle();
        write_reg(mf3_pkg::REG_IMG_W, 32'd2);
        write_reg(mf3_pkg::REG_IMG_H, 32'd0);
        for (int k = 0; k < 3; k++) push_pixel(pick_pixel(), 1'b0);

        // Largest image, with both registers beyond range: the first row runs well past
        // the reset width, so the saturated width holds the right edge back
        settle();
        write_reg(mf3_pkg::REG_IMG_W, 32'd2047);
        write_reg(mf3_pkg::REG_IMG_H, 32'd8191);
        quiet_run = ($urandom_range(0, 1) == 0);
        for (int k = 0; k < LARGE_ITEMS; k++) push_pixel(pick_pixel(), k == 0);

        // Random phases: new register settings, then a run of mostly well-formed frames
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            settle();
            quiet_run = ($urandom_range(0, 4) == 0);
            roll = $urandom_range(0, 19);
            if (roll == 0)      raw_w = $urandom_range(0, 2);
            else if (roll == 1) raw_w = $urandom_range(mf3_pkg::MAX_WIDTH_DEF, 2047);
            else if (roll < 4)  raw_w = $urandom_range(13, 60);
            else                raw_w = $urandom_range(3, 12);
            roll = $urandom_range(0, 19);
            if (roll == 0)      raw_h = $urandom_range(0, 2);
            else if (roll == 1) raw_h = $urandom_range(mf3_pkg::MAX_HEIGHT_DEF, 8191);
            else if (roll < 4)  raw_h = $urandom_range(13, 40);
            else                raw_h = $urandom_range(3, 10);
            roll = $urandom_range(0, 3);
            if (roll != 1) write_reg(mf3_pkg::REG_IMG_W, raw_w);
            if (roll != 0) write_reg(mf3_pkg::REG_IMG_H, raw_h);
            n_items = $urandom_range(20, 120);
            for (int k = 0; k < n_items; k++) begin
                // Open the phase with a frame start half the time; break frames rarely
                push_pixel(pick_pixel(), (k == 0) ? ($urandom_range(0, 1) == 0)
                                                  : ($urandom_range(0, 99) == 0));
            end
            random_sent += n_items;
        end

        settle();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
